// ===== rtl/core/obbsat_pkg.sv =====
// ----------------------------------------------------------------------------
// obbsat_pkg
// Shared types, constants and helpers for the oriented-box pair contact block.
// ----------------------------------------------------------------------------
package obbsat_pkg;

   // default trig fraction (Q1.14)
   localparam int TRIG_FRAC_BITS_DEF = 14;

   // result queue depth, in box pairs
   localparam int RES_FIFO_DEPTH = 8;

   // one box as it arrives on the request port
   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic        [30:0] hx;
      logic        [30:0] hy;
      logic signed [15:0] c;
      logic signed [15:0] s;
   } box_type;

   // one finished box pair; contact slots are already in emission order
   typedef struct packed {
      logic              hit;
      logic       [15:0] nx;
      logic       [15:0] ny;
      logic       [30:0] depth;
      logic              refb;
      logic        [3:0] mask;
      logic [3:0] [31:0] px;
      logic [3:0] [31:0] py;
   } res_item_type;

   // clamp to the 32-bit signed range
   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/obb_pair_sat_contact_generation.sv =====
// ----------------------------------------------------------------------------
// obb_pair_sat_contact_generation
// Separating-axis test of two 2D oriented boxes with corner contact points.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive the req_ fields for boxes A and B and raise start;
//   the request is taken at a rising edge with start high and busy low.
//   Result channel: each result sits on the rsp_ ports for one cycle with
//   rsp_strobe high. A separated pair gives one result with hit clear; an
//   overlapping pair gives one result per incident corner inside the
//   reference box (up to four), or one result without a contact. rsp_last
//   marks the final result of each pair.
//   A request passes seven pipeline stages, the first loading at the edge
//   that takes it, then the result queue and the output register.
//   A new request can enter every cycle while busy is low; the result port
//   emits one result per cycle, so a pair takes one to four results of
//   output and the sustained rate is set by the number of contacts per pair.
//   busy rises while the eight-pair result queue has no free credit.
//   Reset clears all valid bits, the queue and the credits; no results are
//   lost afterwards because the receiver never stalls.
// ----------------------------------------------------------------------------
module obb_pair_sat_contact_generation import obbsat_pkg::*; #(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
   parameter int FIFO_DEPTH     = RES_FIFO_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_a_center_x,
   input  logic signed [31:0] req_a_center_y,
   input  logic        [30:0] req_a_half_x,
   input  logic        [30:0] req_a_half_y,
   input  logic signed [15:0] req_a_cos,
   input  logic signed [15:0] req_a_sin,
   input  logic signed [31:0] req_b_center_x,
   input  logic signed [31:0] req_b_center_y,
   input  logic        [30:0] req_b_half_x,
   input  logic        [30:0] req_b_half_y,
   input  logic signed [15:0] req_b_cos,
   input  logic signed [15:0] req_b_sin,
   output logic               rsp_strobe,
   output logic               rsp_hit,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic        [30:0] rsp_depth,
   output logic               rsp_reference_is_b,
   output logic               rsp_contact_valid,
   output logic signed [31:0] rsp_contact_x,
   output logic signed [31:0] rsp_contact_y,
   output logic               rsp_last
);

   localparam int KW  = 49 - TRIG_FRAC_BITS;
   localparam int PTW = KW + 2;
   localparam int PW  = KW + 21;

   logic                  accept;
   box_type               req_box [2];
   logic                  c_valid, p_valid, s_valid;
   box_type               c_box [2], p_box [2];
   logic signed [KW-1:0]  c_kx [2][4], c_ky [2][4];
   logic                  p_sep;
   logic signed [PW-1:0]  p_pen [4];
   logic           [3:0]  p_rel;
   logic           [3:0]  p_inside [2];
   logic signed [PTW-1:0] p_ptx [2][4], p_pty [2][4];
   res_item_type          s_item;

   // take a request when idle credit allows
   assign accept = start && !busy;

   assign req_box[0] = '{cx: req_a_center_x, cy: req_a_center_y, hx: req_a_half_x,
                         hy: req_a_half_y, c: req_a_cos, s: req_a_sin};
   assign req_box[1] = '{cx: req_b_center_x, cy: req_b_center_y, hx: req_b_half_x,
                         hy: req_b_half_y, c: req_b_cos, s: req_b_sin};

   obbsat_corner #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_corner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_box    (req_box),
      .out_valid (c_valid),
      .out_box   (c_box),
      .out_kx    (c_kx),
      .out_ky    (c_ky)
   );

   obbsat_project #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_project (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (c_valid),
      .in_box     (c_box),
      .in_kx      (c_kx),
      .in_ky      (c_ky),
      .out_valid  (p_valid),
      .out_box    (p_box),
      .out_sep    (p_sep),
      .out_pen    (p_pen),
      .out_rel    (p_rel),
      .out_inside (p_inside),
      .out_ptx    (p_ptx),
      .out_pty    (p_pty)
   );

   obbsat_select #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_box    (p_box),
      .in_sep    (p_sep),
      .in_pen    (p_pen),
      .in_rel    (p_rel),
      .in_inside (p_inside),
      .in_ptx    (p_ptx),
      .in_pty    (p_pty),
      .out_valid (s_valid),
      .out_item  (s_item)
   );

   obbsat_emit #(.FIFO_DEPTH(FIFO_DEPTH)) u_emit (
      .clock              (clock),
      .reset              (reset),
      .req_accept         (accept),
      .in_valid           (s_valid),
      .in_item            (s_item),
      .busy               (busy),
      .rsp_strobe         (rsp_strobe),
      .rsp_hit            (rsp_hit),
      .rsp_normal_x       (rsp_normal_x),
      .rsp_normal_y       (rsp_normal_y),
      .rsp_depth          (rsp_depth),
      .rsp_reference_is_b (rsp_reference_is_b),
      .rsp_contact_valid  (rsp_contact_valid),
      .rsp_contact_x      (rsp_contact_x),
      .rsp_contact_y      (rsp_contact_y),
      .rsp_last           (rsp_last)
   );

endmodule

// ===== rtl/core/obbsat_corner.sv =====
// ----------------------------------------------------------------------------
// obbsat_corner
// Two stages: half-extent by trig products, then the four rotated corners.
// ----------------------------------------------------------------------------
module obbsat_corner import obbsat_pkg::*; #(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
   localparam int KW = 49 - TRIG_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  box_type              in_box [2],
   output logic                 out_valid,
   output box_type              out_box [2],
   output logic signed [KW-1:0] out_kx [2][4],
   output logic signed [KW-1:0] out_ky [2][4]
);

   logic                 v1_ff, v1_in, v2_ff, v2_in;
   box_type              box1_ff [2];
   box_type              box2_ff [2];
   logic signed [47:0]   pxc_in [2], pys_in [2], pxs_in [2], pyc_in [2];
   logic signed [47:0]   pxc_ff [2], pys_ff [2], pxs_ff [2], pyc_ff [2];
   logic signed [KW-1:0] kx_in [2][4], ky_in [2][4];
   logic signed [KW-1:0] kx_ff [2][4], ky_ff [2][4];

   assign v1_in = in_valid;
   assign v2_in = v1_ff;

   // form the half-extent by trig products
   always_comb begin
      logic signed [31:0] hxs, hys;
      for (int b = 0; b < 2; b++) begin
         hxs = $signed({1'b0, in_box[b].hx});
         hys = $signed({1'b0, in_box[b].hy});
         pxc_in[b] = hxs * in_box[b].c;
         pys_in[b] = hys * in_box[b].s;
         pxs_in[b] = hxs * in_box[b].s;
         pyc_in[b] = hys * in_box[b].c;
      end
   end

   // combine into corners, floor shift by the trig fraction
   always_comb begin
      logic signed [48:0] xc, ys, xs, yc;
      for (int b = 0; b < 2; b++) begin
         xc = pxc_ff[b];
         ys = pys_ff[b];
         xs = pxs_ff[b];
         yc = pyc_ff[b];
         kx_in[b][0] = KW'((xc - ys) >>> TRIG_FRAC_BITS);
         kx_in[b][1] = KW'((xc + ys) >>> TRIG_FRAC_BITS);
         kx_in[b][2] = KW'((ys - xc) >>> TRIG_FRAC_BITS);
         kx_in[b][3] = KW'((49'sd0 - xc - ys) >>> TRIG_FRAC_BITS);
         ky_in[b][0] = KW'((xs + yc) >>> TRIG_FRAC_BITS);
         ky_in[b][1] = KW'((xs - yc) >>> TRIG_FRAC_BITS);
         ky_in[b][2] = KW'((49'sd0 - xs - yc) >>> TRIG_FRAC_BITS);
         ky_in[b][3] = KW'((yc - xs) >>> TRIG_FRAC_BITS);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      box1_ff <= in_box;
      pxc_ff  <= pxc_in;
      pys_ff  <= pys_in;
      pxs_ff  <= pxs_in;
      pyc_ff  <= pyc_in;
      box2_ff <= box1_ff;
      kx_ff   <= kx_in;
      ky_ff   <= ky_in;
   end

   assign out_valid = v2_ff;
   assign out_box   = box2_ff;
   assign out_kx    = kx_ff;
   assign out_ky    = ky_ff;

endmodule

// ===== rtl/core/obbsat_project.sv =====
// ----------------------------------------------------------------------------
// obbsat_project
// Four stages: axis products, dot sums, extents, then overlap and side tests.
// ----------------------------------------------------------------------------
module obbsat_project import obbsat_pkg::*; #(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
   localparam int KW  = 49 - TRIG_FRAC_BITS,
   localparam int PTW = KW + 2,
   localparam int PW  = KW + 21
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  box_type               in_box [2],
   input  logic signed [KW-1:0]  in_kx [2][4],
   input  logic signed [KW-1:0]  in_ky [2][4],
   output logic                  out_valid,
   output box_type               out_box [2],
   output logic                  out_sep,
   output logic signed [PW-1:0]  out_pen [4],
   output logic           [3:0]  out_rel,
   output logic           [3:0]  out_inside [2],
   output logic signed [PTW-1:0] out_ptx [2][4],
   output logic signed [PTW-1:0] out_pty [2][4]
);

   localparam int CW = 49;
   localparam int MW = KW + 17;

   logic v3_ff, v3_in, v4_ff, v4_in, v5_ff, v5_in, v6_ff, v6_in;
   box_type box3_ff [2], box4_ff [2], box5_ff [2], box6_ff [2];

   // stage 3
   logic signed [CW-1:0]  cpx_in [4][2], cpy_in [4][2], cpx_ff [4][2], cpy_ff [4][2];
   logic signed [MW-1:0]  kpx_in [4][2][4], kpy_in [4][2][4];
   logic signed [MW-1:0]  kpx_ff [4][2][4], kpy_ff [4][2][4];
   logic signed [PTW-1:0] ptx_in [2][4], pty_in [2][4];
   logic signed [PTW-1:0] ptx3_ff [2][4], pty3_ff [2][4];
   logic signed [PTW-1:0] dx_in [2][4], dy_in [2][4], dx_ff [2][4], dy_ff [2][4];
   // stage 4
   logic signed [PW-1:0]  cdot_in [4][2], cdot4_ff [4][2];
   logic signed [PW-1:0]  kdot_in [4][2][4], kdot_ff [4][2][4];
   logic signed [PW-1:0]  e1x_in [2][4], e1y_in [2][4], e2x_in [2][4], e2y_in [2][4];
   logic signed [PW-1:0]  e1x_ff [2][4], e1y_ff [2][4], e2x_ff [2][4], e2y_ff [2][4];
   logic signed [PTW-1:0] ptx4_ff [2][4], pty4_ff [2][4];
   // stage 5
   logic signed [PW-1:0]  lo_in [4][2], hi_in [4][2], lo_ff [4][2], hi_ff [4][2];
   logic signed [PW-1:0]  cdot5_ff [4][2];
   logic signed [PW-1:0]  d1_in [2][4], d2_in [2][4], d1_ff [2][4], d2_ff [2][4];
   logic signed [PTW-1:0] ptx5_ff [2][4], pty5_ff [2][4];
   // stage 6
   logic                  sep_in, sep_ff;
   logic signed [PW-1:0]  pen_in [4], pen_ff [4];
   logic           [3:0]  rel_in, rel_ff;
   logic           [3:0]  ins_in [2], ins_ff [2];
   logic signed [PTW-1:0] ptx6_ff [2][4], pty6_ff [2][4];

   assign v3_in = in_valid;
   assign v4_in = v3_ff;
   assign v5_in = v4_ff;
   assign v6_in = v5_ff;

   // project centres and corners onto the four axes; form corner points
   always_comb begin
      logic signed [16:0] ux [4];
      logic signed [16:0] uy [4];
      logic signed [16:0] cc, ss;
      for (int b = 0; b < 2; b++) begin
         cc = in_box[b].c;
         ss = in_box[b].s;
         ux[2*b]   = cc;
         uy[2*b]   = ss;
         ux[2*b+1] = -ss;
         uy[2*b+1] = cc;
      end
      for (int a = 0; a < 4; a++) begin
         for (int b = 0; b < 2; b++) begin
            cpx_in[a][b] = in_box[b].cx * ux[a];
            cpy_in[a][b] = in_box[b].cy * uy[a];
            for (int k = 0; k < 4; k++) begin
               kpx_in[a][b][k] = in_kx[b][k] * ux[a];
               kpy_in[a][b][k] = in_ky[b][k] * uy[a];
            end
         end
      end
      for (int b = 0; b < 2; b++) begin
         for (int k = 0; k < 4; k++) begin
            ptx_in[b][k] = in_box[b].cx + in_kx[b][k];
            pty_in[b][k] = in_box[b].cy + in_ky[b][k];
         end
      end
      // offsets of incident corners from the reference centre
      for (int r = 0; r < 2; r++) begin
         for (int k = 0; k < 4; k++) begin
            dx_in[r][k] = ptx_in[1-r][k] - in_box[r].cx;
            dy_in[r][k] = pty_in[1-r][k] - in_box[r].cy;
         end
      end
   end

   // sum the dot products; multiply offsets by the reference axes
   always_comb begin
      logic signed [16:0] cr, sr, nsr;
      for (int a = 0; a < 4; a++) begin
         for (int b = 0; b < 2; b++) begin
            cdot_in[a][b] = cpx_ff[a][b] + cpy_ff[a][b];
            for (int k = 0; k < 4; k++) begin
               kdot_in[a][b][k] = kpx_ff[a][b][k] + kpy_ff[a][b][k];
            end
         end
      end
      for (int r = 0; r < 2; r++) begin
         cr  = box3_ff[r].c;
         sr  = box3_ff[r].s;
         nsr = -sr;
         for (int k = 0; k < 4; k++) begin
            e1x_in[r][k] = dx_ff[r][k] * cr;
            e1y_in[r][k] = dy_ff[r][k] * sr;
            e2x_in[r][k] = dx_ff[r][k] * nsr;
            e2y_in[r][k] = dy_ff[r][k] * cr;
         end
      end
   end

   // widen each interval from zero by its corners; finish the side distances
   always_comb begin
      for (int a = 0; a < 4; a++) begin
         for (int b = 0; b < 2; b++) begin
            lo_in[a][b] = '0;
            hi_in[a][b] = '0;
            for (int k = 0; k < 4; k++) begin
               if (kdot_ff[a][b][k] < lo_in[a][b]) begin
                  lo_in[a][b] = kdot_ff[a][b][k];
               end
               if (kdot_ff[a][b][k] > hi_in[a][b]) begin
                  hi_in[a][b] = kdot_ff[a][b][k];
               end
            end
         end
      end
      for (int r = 0; r < 2; r++) begin
         for (int k = 0; k < 4; k++) begin
            d1_in[r][k] = e1x_ff[r][k] + e1y_ff[r][k];
            d2_in[r][k] = e2x_ff[r][k] + e2y_ff[r][k];
         end
      end
   end

   // overlap, penetration and side-plane tests
   always_comb begin
      logic signed [PW-1:0] p1, p2, e1, e2, limx, limy;
      sep_in = 1'b0;
      for (int a = 0; a < 4; a++) begin
         p1 = cdot5_ff[a][0];
         p2 = cdot5_ff[a][1];
         if (p1 <= p2) begin
            e1 = p1 + hi_ff[a][0];
            e2 = p2 + lo_ff[a][1];
         end else begin
            e1 = p2 + hi_ff[a][1];
            e2 = p1 + lo_ff[a][0];
         end
         if (e1 < e2) begin
            sep_in = 1'b1;
         end
         pen_in[a] = e1 - e2;
         rel_in[a] = (p2 > p1);
      end
      for (int r = 0; r < 2; r++) begin
         limx = {{(PW-31){1'b0}}, box5_ff[r].hx} << TRIG_FRAC_BITS;
         limy = {{(PW-31){1'b0}}, box5_ff[r].hy} << TRIG_FRAC_BITS;
         for (int k = 0; k < 4; k++) begin
            ins_in[r][k] = (d1_ff[r][k] <= limx) && (-d1_ff[r][k] <= limx) &&
                           (d2_ff[r][k] <= limy) && (-d2_ff[r][k] <= limy);
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      box3_ff  <= in_box;
      cpx_ff   <= cpx_in;
      cpy_ff   <= cpy_in;
      kpx_ff   <= kpx_in;
      kpy_ff   <= kpy_in;
      ptx3_ff  <= ptx_in;
      pty3_ff  <= pty_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      box4_ff  <= box3_ff;
      cdot4_ff <= cdot_in;
      kdot_ff  <= kdot_in;
      e1x_ff   <= e1x_in;
      e1y_ff   <= e1y_in;
      e2x_ff   <= e2x_in;
      e2y_ff   <= e2y_in;
      ptx4_ff  <= ptx3_ff;
      pty4_ff  <= pty3_ff;
      box5_ff  <= box4_ff;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      cdot5_ff <= cdot4_ff;
      d1_ff    <= d1_in;
      d2_ff    <= d2_in;
      ptx5_ff  <= ptx4_ff;
      pty5_ff  <= pty4_ff;
      box6_ff  <= box5_ff;
      sep_ff   <= sep_in;
      pen_ff   <= pen_in;
      rel_ff   <= rel_in;
      ins_ff   <= ins_in;
      ptx6_ff  <= ptx5_ff;
      pty6_ff  <= pty5_ff;
   end

   assign out_valid  = v6_ff;
   assign out_box    = box6_ff;
   assign out_sep    = sep_ff;
   assign out_pen    = pen_ff;
   assign out_rel    = rel_ff;
   assign out_inside = ins_ff;
   assign out_ptx    = ptx6_ff;
   assign out_pty    = pty6_ff;

endmodule

// ===== rtl/core/obbsat_select.sv =====
// ----------------------------------------------------------------------------
// obbsat_select
// Pick the least-penetration axis and pack the finished box pair.
// ----------------------------------------------------------------------------
module obbsat_select import obbsat_pkg::*; #(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
   localparam int KW  = 49 - TRIG_FRAC_BITS,
   localparam int PTW = KW + 2,
   localparam int PW  = KW + 21
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  box_type               in_box [2],
   input  logic                  in_sep,
   input  logic signed [PW-1:0]  in_pen [4],
   input  logic           [3:0]  in_rel,
   input  logic           [3:0]  in_inside [2],
   input  logic signed [PTW-1:0] in_ptx [2][4],
   input  logic signed [PTW-1:0] in_pty [2][4],
   output logic                  out_valid,
   output res_item_type          out_item
);

   logic         v7_ff, v7_in;
   res_item_type item_in, item_ff;

   assign v7_in = in_valid;

   // least penetration, earlier axis wins ties
   always_comb begin
      logic [1:0]           best;
      logic                 owner;
      logic [15:0]          ux, uy;
      logic signed [PW-1:0] dd;
      logic [1:0]           src;
      logic signed [63:0]   wx, wy;
      best = 2'd0;
      for (int a = 1; a < 4; a++) begin
         if (in_pen[a] < in_pen[best]) begin
            best = 2'(a);
         end
      end
      owner = best[1];
      if (best[0]) begin
         ux = 16'(-in_box[owner].s);
         uy = in_box[owner].c;
      end else begin
         ux = in_box[owner].c;
         uy = in_box[owner].s;
      end
      if (in_rel[best]) begin
         ux = -ux;
         uy = -uy;
      end
      // floor shift, clamp to the depth range
      dd = in_pen[best] >>> TRIG_FRAC_BITS;
      item_in.hit   = 1'b1;
      item_in.nx    = ux;
      item_in.ny    = uy;
      item_in.refb  = owner;
      if (dd < 0) begin
         item_in.depth = '0;
      end else if (dd > PW'(32'h7FFF_FFFF)) begin
         item_in.depth = 31'h7FFF_FFFF;
      end else begin
         item_in.depth = dd[30:0];
      end
      // incident corners go out in the order 1, 2, 3, 0
      for (int j = 0; j < 4; j++) begin
         src = 2'(j + 1);
         wx  = in_ptx[~owner][src];
         wy  = in_pty[~owner][src];
         item_in.mask[j] = in_inside[owner][src];
         item_in.px[j]   = sat32(wx);
         item_in.py[j]   = sat32(wy);
      end
      // separated pair: a single all-zero result
      if (in_sep) begin
         item_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v7_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = v7_ff;
   assign out_item  = item_ff;

endmodule

// ===== rtl/core/obbsat_emit.sv =====
// ----------------------------------------------------------------------------
// obbsat_emit
// Result queue and emitter: one result per cycle, credits drive busy.
// ----------------------------------------------------------------------------
module obbsat_emit import obbsat_pkg::*; #(
   parameter int FIFO_DEPTH = RES_FIFO_DEPTH,
   localparam int AW = $clog2(FIFO_DEPTH)
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_accept,
   input  logic         in_valid,
   input  res_item_type in_item,
   output logic         busy,
   output logic         rsp_strobe,
   output logic         rsp_hit,
   output logic [15:0]  rsp_normal_x,
   output logic [15:0]  rsp_normal_y,
   output logic [30:0]  rsp_depth,
   output logic         rsp_reference_is_b,
   output logic         rsp_contact_valid,
   output logic [31:0]  rsp_contact_x,
   output logic [31:0]  rsp_contact_y,
   output logic         rsp_last
);

   res_item_type mem_ff [FIFO_DEPTH];
   logic [AW:0]  wr_ff, wr_in, rd_ff, rd_in, cnt;
   logic [AW:0]  credit_ff, credit_in;
   logic [3:0]   done_ff, done_in;
   res_item_type head;
   logic         have, pop;
   logic [3:0]   eff, rest;
   logic [1:0]   sel;
   logic         strobe_ff, hit_ff, refb_ff, cval_ff, last_ff;
   logic [15:0]  nx_ff, ny_ff;
   logic [30:0]  depth_ff;
   logic [31:0]  cx_ff, cy_ff, cx_in, cy_in;

   assign cnt  = wr_ff - rd_ff;
   assign head = mem_ff[rd_ff[AW-1:0]];
   assign have = (cnt != '0);

   // next contact slot of the head pair
   always_comb begin
      eff = head.mask & ~done_ff;
      sel = 2'd0;
      for (int k = 3; k >= 0; k--) begin
         if (eff[k]) begin
            sel = 2'(k);
         end
      end
      rest = eff & ~(4'b0001 << sel);
      pop  = have && ((eff == 4'b0000) || (rest == 4'b0000));
      if (eff != 4'b0000) begin
         cx_in = head.px[sel];
         cy_in = head.py[sel];
      end else begin
         cx_in = '0;
         cy_in = '0;
      end
      if (pop) begin
         done_in = 4'b0000;
      end else if (have) begin
         done_in = done_ff | (4'b0001 << sel);
      end else begin
         done_in = done_ff;
      end
   end

   assign wr_in     = wr_ff + (AW+1)'(in_valid);
   assign rd_in     = rd_ff + (AW+1)'(pop);
   assign credit_in = credit_ff + (AW+1)'(req_accept) - (AW+1)'(pop);
   assign busy      = (credit_ff == (AW+1)'(FIFO_DEPTH));

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff     <= '0;
         rd_ff     <= '0;
         credit_ff <= '0;
         done_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         wr_ff     <= wr_in;
         rd_ff     <= rd_in;
         credit_ff <= credit_in;
         done_ff   <= done_in;
         strobe_ff <= have;
      end
   end

   // queue write and output register
   always_ff @(posedge clock) begin
      if (in_valid) begin
         mem_ff[wr_ff[AW-1:0]] <= in_item;
      end
      hit_ff   <= head.hit;
      nx_ff    <= head.nx;
      ny_ff    <= head.ny;
      depth_ff <= head.depth;
      refb_ff  <= head.refb;
      cval_ff  <= (eff != 4'b0000);
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      last_ff  <= pop;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_hit            = hit_ff;
   assign rsp_normal_x       = nx_ff;
   assign rsp_normal_y       = ny_ff;
   assign rsp_depth          = depth_ff;
   assign rsp_reference_is_b = refb_ff;
   assign rsp_contact_valid  = cval_ff;
   assign rsp_contact_x      = cx_ff;
   assign rsp_contact_y      = cy_ff;
   assign rsp_last           = last_ff;

   a_credit_bound : assert property (@(posedge clock) disable iff (reset)
      credit_ff <= (AW+1)'(FIFO_DEPTH))
      else $error("credit count above queue depth");

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      in_valid |-> (cnt < (AW+1)'(FIFO_DEPTH)))
      else $error("result queue written while full");

   a_queue_in_credit : assert property (@(posedge clock) disable iff (reset)
      cnt <= credit_ff)
      else $error("queued pairs exceed outstanding credits");

   a_contact_hit : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_contact_valid) |-> rsp_hit)
      else $error("contact emitted without a hit");

endmodule
